[rtl/qec_pkg.sv]
`default_nettype none

package qec_pkg;

  // Sequencer states of the quantizer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CARRY,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } state_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROUND_MODE  = 3'd0;
  localparam logic [2:0] REG_CARRY_ERROR = 3'd1;
  localparam logic [2:0] REG_LSB_CH0     = 3'd2;
  localparam logic [2:0] REG_LSB_CH1     = 3'd3;
  localparam logic [2:0] REG_LSB_CH2     = 3'd4;
  localparam logic [2:0] REG_LSB_CH3     = 3'd5;

  // Rounding modes.
  localparam logic [1:0] RND_TO_ZERO   = 2'd0;
  localparam logic [1:0] RND_AWAY      = 2'd1;
  localparam logic [1:0] RND_NEAREST   = 2'd2;
  localparam logic [1:0] RND_NONE      = 2'd3;

  localparam int unsigned LSB_W   = 31;
  localparam int unsigned NUM_REG_CH = 4;
  localparam logic [LSB_W-1:0] LSB_RESET = 31'd65536;

endpackage

`default_nettype wire

[rtl/quantizer_with_error_carry.sv]
`default_nettype none

// Quantizes one signed Q16.16 sample of one channel to a signed multiple of
// that channel's step size (lsb_ch0..lsb_ch3, unsigned Q15.16; a step of zero
// acts as one raw LSB). With carry_error set, the leftover error stored for
// the channel is added to the sample first, saturating to 32 bits. The
// magnitude is rounded to a step multiple toward zero, away from zero, or to
// nearest with ties away from zero, the sign is restored, and the new
// leftover error is stored for the channel. Round mode 3 passes the working
// value through. Any clipping, of the carried sum or of the result, raises
// the saturated flag. Each accepted word passes through the carry state,
// which adds the carried error, a shared restoring divider that forms the
// remainder one bit per cycle, and the round state, which forms the result,
// held until taken. The block takes no new word until the result has been
// taken. The per-channel error store is cleared by reset. The user must write
// configuration only while idle; the block itself does not enforce this.
module quantizer_with_error_carry #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  input  wire logic [1:0]  s_tuser,   // [1:0] channel
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] quantized
  output logic [2:0]       m_tuser,   // [1:0] channel_out, [2] saturated
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  qec_pkg::state_t state, state_next;

  // Configuration registers.
  logic [1:0]               round_mode;
  logic                     carry_error;
  logic [qec_pkg::LSB_W-1:0] lsb [qec_pkg::NUM_REG_CH];

  // Per-channel leftover error.
  logic [31:0] channel_error [NUM_CHANNELS];

  // Working registers for the word in flight.
  logic [1:0]               ch;
  logic                     ch_valid;
  logic [31:0]              work;
  logic                     neg;
  logic [31:0]              mag;
  logic [31:0]              dvd;
  logic [qec_pkg::LSB_W-1:0] step;
  logic [qec_pkg::LSB_W-1:0] rem;
  logic [4:0]               count;
  logic                     sat;
  logic [31:0]              quantized;

  // Datapath signals.
  logic [31:0]              err_rd;
  logic [32:0]              carry_sum;
  logic [31:0]              work_sat;
  logic                     carry_ovf;
  logic [qec_pkg::LSB_W-1:0] lsb_rd;
  logic [31:0]              trial;
  logic                     trial_ge;
  logic                     inc;
  logic [33:0]              prod;
  logic                     prod_clip;
  logic [31:0]              result;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      round_mode  <= qec_pkg::RND_TO_ZERO;
      carry_error <= 1'b0;
      for (int i = 0; i < qec_pkg::NUM_REG_CH; i++) begin
        lsb[i] <= qec_pkg::LSB_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        qec_pkg::REG_ROUND_MODE:  round_mode  <= cfg_data[1:0];
        qec_pkg::REG_CARRY_ERROR: carry_error <= cfg_data[0];
        qec_pkg::REG_LSB_CH0:     lsb[0]      <= cfg_data;
        qec_pkg::REG_LSB_CH1:     lsb[1]      <= cfg_data;
        qec_pkg::REG_LSB_CH2:     lsb[2]      <= cfg_data;
        qec_pkg::REG_LSB_CH3:     lsb[3]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      qec_pkg::ST_IDLE:  if (s_tvalid) state_next = qec_pkg::ST_CARRY;
      qec_pkg::ST_CARRY: state_next = qec_pkg::ST_DIV;
      qec_pkg::ST_DIV:   if (count == 5'd31) state_next = qec_pkg::ST_ROUND;
      qec_pkg::ST_ROUND: state_next = qec_pkg::ST_DONE;
      qec_pkg::ST_DONE:  if (m_tready) state_next = qec_pkg::ST_IDLE;
      default:           state_next = qec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      qec_pkg::ST_IDLE: s_tready = 1'b1;
      qec_pkg::ST_DONE: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata = quantized;
  assign m_tuser = {sat, ch};

  // ---------------------------------------------------------------------
  // Carry add with saturation
  // ---------------------------------------------------------------------
  // Channels beyond the store carry no error.
  assign err_rd    = (carry_error && ch_valid) ? channel_error[ch[CH_W-1:0]] : 32'd0;
  assign carry_sum = {work[31], work} + {err_rd[31], err_rd};
  assign carry_ovf = carry_sum[32] != carry_sum[31];
  assign work_sat  = carry_ovf ? (carry_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                               : carry_sum[31:0];
  assign lsb_rd    = lsb[ch];

  // ---------------------------------------------------------------------
  // Restoring divider step: only the remainder is kept, since the rounded
  // multiple equals the magnitude minus the remainder, plus one step when
  // rounding up.
  // ---------------------------------------------------------------------
  assign trial    = {rem, dvd[31]};
  assign trial_ge = trial >= {1'b0, step};

  // ---------------------------------------------------------------------
  // Rounding and result
  // ---------------------------------------------------------------------
  always_comb begin
    case (round_mode)
      qec_pkg::RND_AWAY:    inc = rem != '0;
      qec_pkg::RND_NEAREST: inc = {rem, 1'b0} >= {1'b0, step};
      default:              inc = 1'b0;
    endcase
    prod = {2'b00, mag} - {3'b000, rem} + (inc ? {3'b000, step} : 34'd0);
    if (neg) begin
      prod_clip = prod > 34'h0_8000_0000;
      result    = prod_clip ? 32'h8000_0000 : 32'(34'd0 - prod);
    end else begin
      prod_clip = prod > 34'h0_7FFF_FFFF;
      result    = prod_clip ? 32'h7FFF_FFFF : prod[31:0];
    end
    if (round_mode == qec_pkg::RND_NONE) begin
      prod_clip = 1'b0;
      result    = work;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      qec_pkg::ST_IDLE: begin
        ch       <= s_tuser;
        ch_valid <= {1'b0, s_tuser} < 3'(NUM_CHANNELS);
        work     <= s_tdata;
        sat      <= 1'b0;
      end
      qec_pkg::ST_CARRY: begin
        work  <= work_sat;
        sat   <= carry_ovf;
        neg   <= work_sat[31];
        mag   <= work_sat[31] ? 32'd0 - work_sat : work_sat;
        dvd   <= work_sat[31] ? 32'd0 - work_sat : work_sat;
        step  <= (lsb_rd == '0) ? qec_pkg::LSB_W'(1) : lsb_rd;
        rem   <= '0;
        count <= 5'd0;
      end
      qec_pkg::ST_DIV: begin
        rem   <= trial_ge ? qec_pkg::LSB_W'(trial - {1'b0, step}) : trial[30:0];
        dvd   <= {dvd[30:0], 1'b0};
        count <= count + 5'd1;
      end
      qec_pkg::ST_ROUND: begin
        quantized <= result;
        sat       <= sat | prod_clip;
      end
      default: ;
    endcase
  end

  // Error store, cleared at reset and written once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_error[i] <= 32'd0;
      end
    end else if (state == qec_pkg::ST_ROUND && ch_valid) begin
      channel_error[ch[CH_W-1:0]] <= work - result;
    end
  end

endmodule

`default_nettype wire
